// File: hw/rtl/tape_pulse_fsk_demodulator_assert.svh
// assertion macros for the tape pulse fsk demodulator
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef TAPE_PULSE_FSK_DEMODULATOR_ASSERT_SVH
`define TAPE_PULSE_FSK_DEMODULATOR_ASSERT_SVH

// implication checked at every clock edge outside reset
`define TPFSK_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpfsk implication check failed");

// invariant checked at every clock edge outside reset
`define TPFSK_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("tpfsk invariant check failed");

`endif

// File: hw/rtl/tpfsk_pkg.sv
// shared types and constants for the tape pulse fsk demodulator
// no dependencies
`default_nettype none

package tpfsk_pkg;

    localparam int LenW  = 32;
    localparam int RateW = 18;
    localparam int CntW  = 30;
    localparam int SymW  = 2;

    // the bit rate 1200 fits in this many bits
    localparam int BaudMulW = 11;
    localparam int DvdW     = LenW + BaudMulW;
    localparam int StepW    = $clog2(DvdW);

    // lengths from this many bits up are always silence
    localparam int SmallW = 8;
    localparam int ProdW  = 20;

    localparam logic [BaudMulW-1:0] BitRate   = 11'd1200;
    localparam logic [ProdW-1:0]    ShortMul  = 20'd3200;
    localparam logic [ProdW-1:0]    LongMul   = 20'd1200;
    localparam logic [RateW-1:0]    RateReset = 18'd44100;

    localparam logic [SymW-1:0] SymZero    = 2'd0;
    localparam logic [SymW-1:0] SymOne     = 2'd1;
    localparam logic [SymW-1:0] SymSilence = 2'd2;

    localparam logic [1:0] ShortRun = 2'd3;

    typedef struct packed {
        logic [LenW-1:0] pulse_length;
        logic            end_of_tape;
    } t_in_beat;

    typedef struct packed {
        logic [SymW-1:0] symbol;
        logic [CntW-1:0] silence_count;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/tape_pulse_fsk_demodulator.sv
// a short or long pulse updates the window and any bit beat goes to the output register
// a silence pulse runs a bit-serial restoring divider, 43 steps, and blocks new pulses
// throughput: 1 pulse per cycle for short and long pulses unless the output stalls
// the next pulse is taken in S_IDLE when the output register is free or draining
// reset clears the pending pulse window and output valid and loads r_rate with 44100
// depends on tpfsk_pkg and tape_pulse_fsk_demodulator_assert.svh
`default_nettype none

`include "tape_pulse_fsk_demodulator_assert.svh"

module tape_pulse_fsk_demodulator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire tpfsk_pkg::t_in_beat          i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output tpfsk_pkg::t_out_beat              o_out_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [tpfsk_pkg::RateW-1:0]  i_cfg_data
);

    tpfsk_pkg::t_state                 r_state, n_state;
    logic [tpfsk_pkg::RateW-1:0]       r_rate;
    logic [1:0]                        r_pend_cnt, n_pend_cnt;
    logic                              r_pend_long, n_pend_long;
    logic [tpfsk_pkg::DvdW-1:0]        r_dvd, n_dvd;
    logic [tpfsk_pkg::RateW-1:0]       r_rem, n_rem;
    logic [tpfsk_pkg::StepW-1:0]       r_step, n_step;
    logic                              r_out_valid, n_out_valid;
    tpfsk_pkg::t_out_beat              r_out_data, n_out_data;

    logic                              in_fire;
    logic                              len_small;
    logic [tpfsk_pkg::ProdW-1:0]       prod_short, prod_long, rate_ext;
    logic                              is_short, is_long;
    logic [tpfsk_pkg::RateW:0]         trial;
    logic                              trial_ge;
    logic                              cnt_ovf;

    // the divider reads the rate, so it only changes between pulses
    assign o_cfg_ready = (r_state == tpfsk_pkg::S_IDLE);
    assign o_in_ready  = (r_state == tpfsk_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // pulse class, exact integer thresholds on the low byte
    assign len_small  = ~|i_in_data.pulse_length[tpfsk_pkg::LenW-1:tpfsk_pkg::SmallW];
    assign prod_short = tpfsk_pkg::ProdW'(i_in_data.pulse_length[tpfsk_pkg::SmallW-1:0])
                        * tpfsk_pkg::ShortMul;
    assign prod_long  = tpfsk_pkg::ProdW'(i_in_data.pulse_length[tpfsk_pkg::SmallW-1:0])
                        * tpfsk_pkg::LongMul;
    assign rate_ext   = tpfsk_pkg::ProdW'(r_rate);
    assign is_short   = len_small && (prod_short <= rate_ext);
    assign is_long    = len_small && (prod_long < rate_ext);

    // one restoring division step, quotient bits shift in behind the dividend
    assign trial    = {r_rem, r_dvd[tpfsk_pkg::DvdW-1]};
    assign trial_ge = trial >= {1'b0, r_rate};
    assign cnt_ovf  = |r_dvd[tpfsk_pkg::DvdW-1:tpfsk_pkg::CntW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpfsk_pkg::S_IDLE;
            r_rate      <= tpfsk_pkg::RateReset;
            r_pend_cnt  <= 2'd0;
            r_pend_long <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_cnt  <= n_pend_cnt;
            r_pend_long <= n_pend_long;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_pend_cnt  = r_pend_cnt;
        n_pend_long = r_pend_long;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        case (r_state)
            tpfsk_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (is_short) begin
                        if (r_pend_long) begin
                            // a pending long is dropped, new run of shorts
                            n_pend_cnt  = 2'd1;
                            n_pend_long = 1'b0;
                        end else if (r_pend_cnt == tpfsk_pkg::ShortRun) begin
                            n_pend_cnt  = 2'd0;
                            n_out_valid = 1'b1;
                            n_out_data  = {tpfsk_pkg::SymOne, tpfsk_pkg::CntW'(0)};
                        end else begin
                            n_pend_cnt = r_pend_cnt + 2'd1;
                        end
                    end else if (is_long) begin
                        if (r_pend_long) begin
                            n_pend_cnt  = 2'd0;
                            n_pend_long = 1'b0;
                            n_out_valid = 1'b1;
                            n_out_data  = {tpfsk_pkg::SymZero, tpfsk_pkg::CntW'(0)};
                        end else begin
                            n_pend_cnt  = 2'd1;
                            n_pend_long = 1'b1;
                        end
                    end else begin
                        n_pend_cnt  = 2'd0;
                        n_pend_long = 1'b0;
                        n_dvd       = tpfsk_pkg::DvdW'(i_in_data.pulse_length)
                                      * tpfsk_pkg::DvdW'(tpfsk_pkg::BitRate);
                        n_rem       = '0;
                        n_step      = '0;
                        n_state     = tpfsk_pkg::S_DIV;
                    end
                    if (i_in_data.end_of_tape) begin
                        n_pend_cnt  = 2'd0;
                        n_pend_long = 1'b0;
                    end
                end
            end
            tpfsk_pkg::S_DIV: begin
                n_dvd  = {r_dvd[tpfsk_pkg::DvdW-2:0], trial_ge};
                n_rem  = trial_ge ? tpfsk_pkg::RateW'(trial - {1'b0, r_rate})
                                  : trial[tpfsk_pkg::RateW-1:0];
                n_step = r_step + 1'b1;
                if (r_step == tpfsk_pkg::StepW'(tpfsk_pkg::DvdW - 1)) begin
                    n_state = tpfsk_pkg::S_DONE;
                end
            end
            tpfsk_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data.symbol        = tpfsk_pkg::SymSilence;
                    n_out_data.silence_count = cnt_ovf ? '1 : r_dvd[tpfsk_pkg::CntW-1:0];
                    n_state = tpfsk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tpfsk_pkg::S_IDLE;
            end
        endcase
    end

    `TPFSK_ASSERT_IMPL(a_ready_only_idle, o_in_ready, r_state == tpfsk_pkg::S_IDLE)
    `TPFSK_ASSERT_ALWAYS(a_long_is_single, !r_pend_long || (r_pend_cnt == 2'd1))
    `TPFSK_ASSERT_IMPL(a_bit_has_no_count,
        o_out_valid && (o_out_data.symbol != tpfsk_pkg::SymSilence),
        o_out_data.silence_count == '0)
    `TPFSK_ASSERT_IMPL(a_div_keeps_window, r_state == tpfsk_pkg::S_DIV,
        (r_pend_cnt == 2'd0) && !r_pend_long)

endmodule

`default_nettype wire
